@@ rtl/hsv_pkg.sv @@
// Shared types and constants of the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

   localparam int DEFAULT_HUE_FRACTION_BITS = 4;

   // Rounded channel = floor(y / SCALE_DIV), where y = (510*v*T >> F) + ROUND_BIAS
   localparam int SCALE_DIV = 1200000;
   localparam int ROUND_BIAS = 600000;
   localparam int Y_WIDTH = 29;

   // Reciprocal of SCALE_DIV; the estimate is low by at most one
   localparam int RECIP_SHIFT = 40;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SCALE_DIV;
   localparam int RECIP_WIDTH = 20;
   localparam int PROD_WIDTH = Y_WIDTH + RECIP_WIDTH;
   localparam int QUOT_WIDTH = 9;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5,
      SECTOR_NONE          = 3'd6
   } sector_type;

   // Stage load enables shared by the three scaling pipes
   typedef struct packed {
      logic mul;
      logic bias;
      logic recip;
      logic fix;
   } hsv_adv_type;

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: hue split, sector select, three scaling pipes.
//
//   channel  direction  ports                                      handshake
//   req      in         req_hue, req_saturation, req_brightness    req_valid / req_stall
//   rsp      out        rsp_red, rsp_green, rsp_blue               rsp_valid / rsp_stall
//
// Six register stages; one item enters per clock while req_stall is low.
// Stage 1 splits hue into sector and ramp, stage 2 builds the per-channel terms,
// stages 3 to 6 multiply by value, scale by 255 and divide by a constant.
// Reset clears only the stage valid bits.
// Each stage holds while the next one is full and stalled; empty stages fill,
// so bubbles close up under rsp_stall and req_stall rises only when all are full.
`default_nettype none

module hsv_to_rgb_converter #(
   parameter int HUE_FRACTION_BITS = hsv_pkg::DEFAULT_HUE_FRACTION_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [12:0] req_hue,
   input  wire logic [6:0]  req_saturation,
   input  wire logic [6:0]  req_brightness,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);
   import hsv_pkg::*;

   localparam int D = 60 << HUE_FRACTION_BITS;
   localparam int DW = $clog2(D+1);
   localparam int TW = $clog2(100*D+1);
   localparam int STAGES = 6;

   logic [STAGES:1] vld_ff, vld_in;
   logic [STAGES:1] ready;
   hsv_adv_type     adv;

   // stage 1
   sector_type      sector_ff, sector_in;
   logic [DW-1:0]   ramp_ff, ramp_in;
   logic [6:0]      sat_ff, sat_in;
   logic [6:0]      val_ff, val_in;
   logic [31:0]     hue_ext;
   logic [31:0]     base;
   logic [DW-1:0]   rem;

   // stage 2
   logic [TW-1:0]   t_red_ff, t_green_ff, t_blue_ff;
   logic [TW-1:0]   t_red_in, t_green_in, t_blue_in;
   logic [6:0]      val2_ff;
   logic [TW-1:0]   t_zero, t_full, t_ramp;

   // handshake: a stage loads when it is empty or its item moves on
   always_comb begin
      ready[STAGES] = !vld_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
      vld_in[1] = req_valid;
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_stall  = !ready[1];
   assign adv.mul    = ready[3];
   assign adv.bias   = ready[4];
   assign adv.recip  = ready[5];
   assign adv.fix    = ready[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (ready[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: clamp percentages, find sector and ramp position
   assign sat_in  = (req_saturation > 7'd100) ? 7'd100 : req_saturation;
   assign val_in  = (req_brightness > 7'd100) ? 7'd100 : req_brightness;
   assign hue_ext = 32'(req_hue);

   always_comb begin
      priority if (hue_ext < 32'(D)) begin
         sector_in = SECTOR_RED_YELLOW;
      end else if (hue_ext < 32'(2*D)) begin
         sector_in = SECTOR_YELLOW_GREEN;
      end else if (hue_ext < 32'(3*D)) begin
         sector_in = SECTOR_GREEN_CYAN;
      end else if (hue_ext < 32'(4*D)) begin
         sector_in = SECTOR_CYAN_BLUE;
      end else if (hue_ext < 32'(5*D)) begin
         sector_in = SECTOR_BLUE_MAGENTA;
      end else if (hue_ext < 32'(6*D)) begin
         sector_in = SECTOR_MAGENTA_RED;
      end else begin
         sector_in = SECTOR_NONE;
      end
   end

   always_comb begin
      unique case (sector_in)
         SECTOR_RED_YELLOW:   base = 32'(0);
         SECTOR_YELLOW_GREEN: base = 32'(D);
         SECTOR_GREEN_CYAN:   base = 32'(2*D);
         SECTOR_CYAN_BLUE:    base = 32'(3*D);
         SECTOR_BLUE_MAGENTA: base = 32'(4*D);
         SECTOR_MAGENTA_RED:  base = 32'(5*D);
         default:             base = 32'(0);
      endcase
      rem = DW'(hue_ext - base);
      if (sector_in == SECTOR_YELLOW_GREEN || sector_in == SECTOR_CYAN_BLUE ||
          sector_in == SECTOR_MAGENTA_RED) begin
         ramp_in = DW'(D) - rem;
      end else begin
         ramp_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         sector_ff <= sector_in;
         ramp_ff   <= ramp_in;
         sat_ff    <= sat_in;
         val_ff    <= val_in;
      end
   end

   // stage 2: terms over D, channel = round(255 * v * T / (10000 * D))
   assign t_zero = TW'(7'd100 - sat_ff) * TW'(D);
   assign t_full = TW'(100 * D);
   assign t_ramp = TW'(sat_ff) * TW'(ramp_ff) + t_zero;

   always_comb begin
      unique case (sector_ff)
         SECTOR_RED_YELLOW: begin
            t_red_in = t_full; t_green_in = t_ramp; t_blue_in = t_zero;
         end
         SECTOR_YELLOW_GREEN: begin
            t_red_in = t_ramp; t_green_in = t_full; t_blue_in = t_zero;
         end
         SECTOR_GREEN_CYAN: begin
            t_red_in = t_zero; t_green_in = t_full; t_blue_in = t_ramp;
         end
         SECTOR_CYAN_BLUE: begin
            t_red_in = t_zero; t_green_in = t_ramp; t_blue_in = t_full;
         end
         SECTOR_BLUE_MAGENTA: begin
            t_red_in = t_ramp; t_green_in = t_zero; t_blue_in = t_full;
         end
         SECTOR_MAGENTA_RED: begin
            t_red_in = t_full; t_green_in = t_zero; t_blue_in = t_ramp;
         end
         default: begin
            t_red_in = t_zero; t_green_in = t_zero; t_blue_in = t_zero;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         t_red_ff   <= t_red_in;
         t_green_ff <= t_green_in;
         t_blue_ff  <= t_blue_in;
         val2_ff    <= val_ff;
      end
   end

   // stages 3 to 6
   hsv_scale #(.HUE_FRACTION_BITS(HUE_FRACTION_BITS)) u_scale_red (
      .clock   (clock),
      .adv     (adv),
      .value   (val2_ff),
      .term    (t_red_ff),
      .channel (rsp_red)
   );

   hsv_scale #(.HUE_FRACTION_BITS(HUE_FRACTION_BITS)) u_scale_green (
      .clock   (clock),
      .adv     (adv),
      .value   (val2_ff),
      .term    (t_green_ff),
      .channel (rsp_green)
   );

   hsv_scale #(.HUE_FRACTION_BITS(HUE_FRACTION_BITS)) u_scale_blue (
      .clock   (clock),
      .adv     (adv),
      .value   (val2_ff),
      .term    (t_blue_ff),
      .channel (rsp_blue)
   );

   assign rsp_valid = vld_ff[STAGES];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[1])
      else $error("accepted item did not enter stage 1");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[1] |-> !req_stall)
      else $error("input stalled with stage 1 empty");

   a_hold_terms: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && !ready[2] |=> vld_ff[2] && $stable(t_red_ff) && $stable(val2_ff))
      else $error("held stage 2 item changed");

   a_gray_out_of_range: assert property (@(posedge clock) disable iff (reset)
      ready[2] && vld_ff[1] && sector_ff == SECTOR_NONE |=>
         t_red_ff == t_green_ff && t_green_ff == t_blue_ff)
      else $error("hue out of range did not give equal terms");

endmodule

`default_nettype wire

@@ rtl/hsv_scale.sv @@
// One color channel: v*T, scale by 255 with rounding, divide by constant.
`default_nettype none

module hsv_scale #(
   parameter int HUE_FRACTION_BITS = hsv_pkg::DEFAULT_HUE_FRACTION_BITS
) (
   input  wire logic                                      clock,
   input  wire hsv_pkg::hsv_adv_type                      adv,
   input  wire logic [6:0]                                value,
   input  wire logic [$clog2(100*(60 << HUE_FRACTION_BITS)+1)-1:0] term,
   output logic [7:0]                                     channel
);
   import hsv_pkg::*;

   localparam int D = 60 << HUE_FRACTION_BITS;
   localparam int VTW = $clog2(100*100*D+1);
   localparam int SCW = VTW + 9;

   logic [VTW-1:0]        vt_ff, vt_in;
   logic [Y_WIDTH-1:0]    y_ff, y_in;
   logic [Y_WIDTH-1:0]    y2_ff;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [7:0]            chan_ff, chan_in;

   logic [SCW-1:0]        scaled;
   logic [QUOT_WIDTH-1:0] q0;
   logic [QUOT_WIDTH-1:0] q1;
   logic [Y_WIDTH-1:0]    back;
   logic [Y_WIDTH-1:0]    rem;

   assign vt_in = VTW'(value) * VTW'(term);

   assign scaled = SCW'(vt_ff) * SCW'(510);
   assign y_in   = Y_WIDTH'(scaled >> HUE_FRACTION_BITS) + Y_WIDTH'(ROUND_BIAS);

   assign prod_in = PROD_WIDTH'(y_ff) * PROD_WIDTH'(RECIP);

   assign q0   = prod_ff[RECIP_SHIFT +: QUOT_WIDTH];
   assign back = Y_WIDTH'(Y_WIDTH'(q0) * Y_WIDTH'(SCALE_DIV));
   assign rem  = y2_ff - back;
   assign q1   = (rem >= Y_WIDTH'(SCALE_DIV)) ? q0 + QUOT_WIDTH'(1) : q0;
   assign chan_in = (q1 > QUOT_WIDTH'(255)) ? 8'd255 : q1[7:0];

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         vt_ff <= vt_in;
      end
      if (adv.bias) begin
         y_ff <= y_in;
      end
      if (adv.recip) begin
         prod_ff <= prod_in;
         y2_ff   <= y_ff;
      end
      if (adv.fix) begin
         chan_ff <= chan_in;
      end
   end

   assign channel = chan_ff;

endmodule

`default_nettype wire

@@ tb/sv/hsv_to_rgb_converter_tb.sv @@
// Self-checking testbench for the HSV to RGB converter: directed and random colors, random flow control.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

   import hsv_pkg::*;

   localparam int HUE_BITS = hsv_pkg::DEFAULT_HUE_FRACTION_BITS;
   localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_BITS;
   localparam longint unsigned HUE_LIMIT = 6 * SECTOR_SPAN;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 250;
   localparam int PRESSURE_ITEMS = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_DIRECTED = 25;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   class color_scoreboard_type;
      rgb_type expected_colors[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      static function logic [7:0] round_to_byte(longint unsigned num, longint unsigned den);
         longint unsigned q;
         q = (num * 510 + den) / (den * 2);
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      static function rgb_type hsv_to_rgb(logic [12:0] hue, logic [6:0] sat_in,
                                          logic [6:0] val_in);
         longint unsigned s, v, den, n_zero, n_full, n_ramp, rem, f;
         longint unsigned rn, gn, bn;
         sector_type sector;
         rgb_type result;
         s = (sat_in > 7'd100) ? 64'd100 : 64'(sat_in);
         v = (val_in > 7'd100) ? 64'd100 : 64'(val_in);
         den = 10000 * SECTOR_SPAN;
         n_zero = v * (100 - s) * SECTOR_SPAN;
         n_full = 100 * v * SECTOR_SPAN;
         n_ramp = n_zero;
         sector = SECTOR_NONE;
         if (hue < HUE_LIMIT) begin
            sector = sector_type'(hue / SECTOR_SPAN);
            rem = hue % SECTOR_SPAN;
            f = sector[0] ? (SECTOR_SPAN - rem) : rem;
            n_ramp = v * s * f + n_zero;
         end
         case (sector)
            SECTOR_RED_YELLOW: begin
               rn = n_full; gn = n_ramp; bn = n_zero;
            end
            SECTOR_YELLOW_GREEN: begin
               rn = n_ramp; gn = n_full; bn = n_zero;
            end
            SECTOR_GREEN_CYAN: begin
               rn = n_zero; gn = n_full; bn = n_ramp;
            end
            SECTOR_CYAN_BLUE: begin
               rn = n_zero; gn = n_ramp; bn = n_full;
            end
            SECTOR_BLUE_MAGENTA: begin
               rn = n_ramp; gn = n_zero; bn = n_full;
            end
            SECTOR_MAGENTA_RED: begin
               rn = n_full; gn = n_zero; bn = n_ramp;
            end
            default: begin
               rn = n_zero; gn = n_zero; bn = n_zero;
            end
         endcase
         result.red = round_to_byte(rn, den);
         result.green = round_to_byte(gn, den);
         result.blue = round_to_byte(bn, den);
         return result;
      endfunction

      function void note_color(logic [12:0] hue, logic [6:0] sat, logic [6:0] val);
         expected_colors.push_back(hsv_to_rgb(hue, sat, val));
      endfunction

      function void check_color(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         rgb_type exp_rgb;
         if (expected_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: got r=%0d g=%0d b=%0d", red, green, blue);
            return;
         end
         exp_rgb = expected_colors.pop_front();
         if (red !== exp_rgb.red || green !== exp_rgb.green || blue !== exp_rgb.blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("color mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        exp_rgb.red, exp_rgb.green, exp_rgb.blue, red, green, blue);
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [12:0] req_hue;
   logic [6:0]  req_saturation;
   logic [6:0]  req_brightness;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   color_scoreboard_type sb;
   int tx_idle_pct;
   int rx_stall_pct;
   int hold_request;
   int hold_left;
   int cycle_count;

   int dir_hue[NUM_DIRECTED] = '{0, 5759, 5760, 5760, 8191, 960, 1920, 2880, 3840, 4800,
                                 480, 1440, 2400, 3360, 4320, 5280, 100, 100, 100, 3000,
                                 7, 959, 961, 4799, 5000};
   int dir_sat[NUM_DIRECTED] = '{100, 100, 100, 50, 0, 100, 100, 100, 100, 100,
                                 100, 60, 60, 60, 60, 60, 0, 127, 101, 100,
                                 0, 100, 37, 100, 1};
   int dir_val[NUM_DIRECTED] = '{100, 100, 100, 80, 100, 100, 100, 100, 100, 100,
                                 100, 70, 70, 70, 70, 70, 0, 127, 100, 127,
                                 100, 100, 53, 1, 100};

   hsv_to_rgb_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_color(req_hue, req_saturation, req_brightness);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_color(rsp_red, rsp_green, rsp_blue);
      end
   end

   // Leaves valid high after acceptance; the caller lowers it or offers the next item.
   task automatic send_color(input logic [12:0] hue, input logic [6:0] sat,
                             input logic [6:0] val);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
   endtask

   task automatic send_random_colors(input int count);
      logic [12:0] hue;
      logic [6:0]  sat;
      logic [6:0]  val;
      int          pick;
      int          edge_hue;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            hue = 13'($urandom_range(32'(HUE_LIMIT - 1), 0));
         end else if (pick < 92) begin
            edge_hue = int'($urandom_range(6, 0) * SECTOR_SPAN + $urandom_range(2, 0)) - 1;
            hue = (edge_hue < 0) ? 13'd0 : edge_hue[12:0];
         end else begin
            hue = 13'($urandom_range(8191, 32'(HUE_LIMIT)));
         end
         sat = ($urandom_range(99) < 90) ? 7'($urandom_range(100, 0)) :
                                           7'($urandom_range(127, 0));
         val = ($urandom_range(99) < 90) ? 7'($urandom_range(100, 0)) :
                                           7'($urandom_range(127, 0));
         send_color(hue, sat, val);
      end
   endtask

   initial begin
      sb = new();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_request = 0;
      reset = 1'b1;
      req_valid <= 1'b0;
      req_hue <= '0;
      req_saturation <= '0;
      req_brightness <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_color(13'(dir_hue[i]), 7'(dir_sat[i]), 7'(dir_val[i]));

      send_random_colors(RANDOM_PER_PHASE);
      tx_idle_pct = 49;
      send_random_colors(RANDOM_PER_PHASE);
      tx_idle_pct = 0;
      rx_stall_pct = 49;
      send_random_colors(RANDOM_PER_PHASE);
      tx_idle_pct = 7;
      rx_stall_pct = 7;
      send_random_colors(RANDOM_PER_PHASE);

      // back pressure: receiver holds off while the sender keeps offering
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_request = HOLD_OFF_CYCLES;
      send_random_colors(PRESSURE_ITEMS);
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hsv_pkg.sv
rtl/hsv_scale.sv
rtl/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_tb.sv
